>>> src/rdsm_pkg.sv
// ----------------------------------------------------------------------------
// rdsm_pkg: shared types and constants for the dot-star matcher
// Command codes, special pattern bytes and the per-cycle control word that
// the top level broadcasts to every column cell.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsm_pkg;

  // Pattern bytes with special meaning
  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] DotByte  = 8'h2E;

  // Input word command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_TEXT  = 2'd2
  } cmd_e;

  // Control broadcast to all cells for one accepted word
  typedef struct packed {
    logic       clr;    // pattern load: clear the match row
    logic       seed;   // begin: seed the row for empty text
    logic       step;   // text byte: advance the row
    logic [7:0] tc;     // text byte
  } cell_ctrl_t;

  // Pattern byte accepts text byte
  function automatic logic byte_fits(logic [7:0] pc, logic [7:0] tc);
    byte_fits = (pc == DotByte) || (pc == tc);
  endfunction

endpackage

`default_nettype wire

>>> src/regex_dot_star_matcher.sv
// ----------------------------------------------------------------------------
// regex_dot_star_matcher: streaming '.'/'*' pattern matcher
// A row of column cells holds the pattern and the match row; each begin or
// text word updates the row and returns the full-match bit.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata                              tuser
//  s_axis    in   [7:0] ch                           [1:0] cmd, [2] first
//  m_axis    out  [0] matched, [1] pattern_overflow  -
//
//  One word per cycle while s_axis_tready is high; a begin or text word yields
//  its result word in the register in the next cycle, a load word yields none.
//  The match row ripples through the cells within the cycle along '*' columns.
//  Reset empties the pattern, clears the match row and the overflow flag.
//  s_axis_tready drops only while a result is held and m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module regex_dot_star_matcher #(
  parameter int PAT_MAX = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] ch
  input  wire  [2:0] s_axis_tuser,   // [1:0] cmd, [2] first
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, rest 0
);

  localparam int LW = $clog2(PAT_MAX + 1);

  rdsm_pkg::cmd_e       cmd;
  rdsm_pkg::cell_ctrl_t ctrl;
  logic                 accept, first;
  logic [LW-1:0]        len_q, len_d, len_base;
  logic                 ovf_q, ovf_d;
  logic                 row0_q, row0_d;
  logic                 out_vld_q, out_vld_d;
  logic                 matched_q;
  logic                 res_ovf_q;
  logic                 produce;

  logic [PAT_MAX:0]     col_nxt;
  logic [PAT_MAX:0]     col_m;
  logic [7:0]           col_pc [PAT_MAX+1];

  assign cmd    = rdsm_pkg::cmd_e'(s_axis_tuser[1:0]);
  assign first  = s_axis_tuser[2];
  assign accept = s_axis_tvalid && s_axis_tready;

  // Control word for the cells
  always_comb begin
    ctrl      = '0;
    ctrl.tc   = s_axis_tdata;
    produce   = 1'b0;
    if (accept) begin
      case (cmd)
        rdsm_pkg::CMD_LOAD:  ctrl.clr = 1'b1;
        rdsm_pkg::CMD_BEGIN: begin
          ctrl.seed = 1'b1;
          produce   = 1'b1;
        end
        rdsm_pkg::CMD_TEXT: begin
          ctrl.step = 1'b1;
          produce   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Pattern length and overflow
  assign len_base = first ? '0 : len_q;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (ctrl.clr) begin
      if (first) begin
        ovf_d = 1'b0;
      end
      if (len_base < LW'(PAT_MAX)) begin
        len_d = len_base + LW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // Column zero: empty pattern prefix
  always_comb begin
    row0_d = row0_q;
    if (ctrl.seed) begin
      row0_d = 1'b1;
    end else if (ctrl.step || ctrl.clr) begin
      row0_d = 1'b0;
    end
  end

  assign col_nxt[0] = ctrl.seed;
  assign col_m[0]   = row0_q;
  assign col_pc[0]  = '0;

  // Row of column cells
  for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
    rdsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_i       (ctrl.clr && (len_base == LW'(k))),
      .wr_byte_i  (s_axis_tdata),
      .active_i   (LW'(k) < len_q),
      .has_left_i (k != 0),
      .left_pc_i  (col_pc[k]),
      .left_m_i   (col_m[k]),
      .skip_i     ((k == 0) ? 1'b0 : col_nxt[(k == 0) ? 0 : k - 1]),
      .pc_o       (col_pc[k+1]),
      .m_o        (col_m[k+1]),
      .nxt_o      (col_nxt[k+1])
    );
  end

  // Output register
  assign s_axis_tready = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (produce) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      matched_q <= col_nxt[len_q];
      res_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      ovf_q     <= 1'b0;
      row0_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      row0_q    <= row0_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, res_ovf_q, matched_q};

  // Checks
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(PAT_MAX))
    else $error("pattern length beyond capacity");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == rdsm_pkg::CMD_LOAD) && !out_vld_q |=> !out_vld_q)
    else $error("load produced a result word");

  a_text_clears_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == rdsm_pkg::CMD_TEXT) |=> !row0_q)
    else $error("empty prefix still matching after text");

  a_begin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == rdsm_pkg::CMD_BEGIN) && (len_q == '0) |=> out_vld_q && matched_q)
    else $error("empty pattern must match at begin");

endmodule

`default_nettype wire

>>> src/rdsm_cell.sv
// ----------------------------------------------------------------------------
// rdsm_cell: one pattern column of the matcher
// Holds one pattern byte and the match bit for its column. Takes the left
// neighbor's byte and match bit and the new bit two columns back, and
// computes this column's new bit for seed and advance.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsm_cell (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire rdsm_pkg::cell_ctrl_t ctrl_i,
  input  wire                     wr_i,        // store wr_byte_i as pattern byte
  input  wire  [7:0]              wr_byte_i,
  input  wire                     active_i,    // column lies within pattern
  input  wire                     has_left_i,  // a pattern byte exists to the left
  input  wire  [7:0]              left_pc_i,
  input  wire                     left_m_i,    // old match bit of left column
  input  wire                     skip_i,      // new match bit two columns left
  output logic [7:0]              pc_o,
  output logic                    m_o,
  output logic                    nxt_o        // new match bit of this column
);

  logic [7:0] pc_q;
  logic       m_q, m_d;
  logic       is_star;

  // Pattern byte, no reset needed
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      pc_q <= wr_byte_i;
    end
  end

  assign is_star = (pc_q == rdsm_pkg::StarByte);

  // Column update rule
  always_comb begin
    nxt_o = 1'b0;
    if (active_i) begin
      if (ctrl_i.seed) begin
        nxt_o = is_star && has_left_i && skip_i;
      end else if (ctrl_i.step) begin
        if (is_star) begin
          nxt_o = has_left_i &&
                  (skip_i || (rdsm_pkg::byte_fits(left_pc_i, ctrl_i.tc) && m_q));
        end else begin
          nxt_o = left_m_i && rdsm_pkg::byte_fits(pc_q, ctrl_i.tc);
        end
      end
    end
  end

  always_comb begin
    m_d = m_q;
    if (ctrl_i.clr) begin
      m_d = 1'b0;
    end else if (ctrl_i.seed || ctrl_i.step) begin
      m_d = nxt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= 1'b0;
    end else begin
      m_q <= m_d;
    end
  end

  assign pc_o = pc_q;
  assign m_o  = m_q;

endmodule

`default_nettype wire
